@@ hdl/sc1kd_pkg.sv @@
package sc1kd_pkg;

	localparam int IN_W  = 8;
	localparam int OUT_W = 40;

	// prefix bytes
	localparam logic [7:0] SC_PFX_E0 = 8'hE0;
	localparam logic [7:0] SC_PFX_E1 = 8'hE1;

	// 7-bit scan codes with special handling
	localparam logic [6:0] CODE_CTRL      = 7'h1D;
	localparam logic [6:0] CODE_LSHIFT    = 7'h2A;
	localparam logic [6:0] CODE_RSHIFT    = 7'h36;
	localparam logic [6:0] CODE_ALT       = 7'h38;
	localparam logic [6:0] CODE_CAPS      = 7'h3A;
	localparam logic [6:0] CODE_NUM       = 7'h45;
	localparam logic [6:0] CODE_SCROLL    = 7'h46;
	localparam logic [6:0] CODE_PAD_FIRST = 7'h47;
	localparam logic [6:0] CODE_PAD_LAST  = 7'h53;
	localparam logic [6:0] CODE_SLASH     = 7'h35;
	localparam logic [6:0] CODE_STAR      = 7'h37;
	localparam logic [6:0] CODE_PAUSE     = 7'h7F;

	localparam logic [7:0] VK_NUM_SLASH = 8'h6F;
	localparam logic [7:0] VK_SNAPSHOT  = 8'h2A;

	// modifier bit positions
	localparam int MOD_RALT   = 0;
	localparam int MOD_LALT   = 1;
	localparam int MOD_RCTRL  = 2;
	localparam int MOD_LCTRL  = 3;
	localparam int MOD_SHIFT  = 4;
	localparam int MOD_NUM    = 5;
	localparam int MOD_SCROLL = 6;
	localparam int MOD_CAPS   = 7;

	// LED bit positions
	localparam int LED_SCROLL = 0;
	localparam int LED_NUM    = 1;
	localparam int LED_CAPS   = 2;

	// held-lock bit positions
	localparam int HELD_CAPS   = 0;
	localparam int HELD_NUM    = 1;
	localparam int HELD_SCROLL = 2;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_E0,
		PFX_E1,
		PFX_E1_1D
	} pfx_t;

	typedef struct packed {
		logic       ext;
		pfx_t       pfx;
		logic [7:0] mods;
		logic [2:0] led;
		logic [2:0] held;
	} kbd_state_t;

	// first field in the highest bits, last field in the lowest bits
	typedef struct packed {
		logic [2:0] led_bits;
		logic       led_update;
		logic [8:0] control_state;
		logic [6:0] ascii_char;
		logic [6:0] key_scan;
		logic [7:0] virtual_key;
		logic       key_down;
	} key_event_t;

	function automatic logic [7:0] base_vk(input logic [6:0] code);
		logic [7:0] vk;
		unique case (code)
			7'h01: vk = 8'h1B; 7'h02: vk = 8'h31; 7'h03: vk = 8'h32; 7'h04: vk = 8'h33;
			7'h05: vk = 8'h34; 7'h06: vk = 8'h35; 7'h07: vk = 8'h36; 7'h08: vk = 8'h37;
			7'h09: vk = 8'h38; 7'h0A: vk = 8'h39; 7'h0B: vk = 8'h30; 7'h0C: vk = 8'hBD;
			7'h0D: vk = 8'hBB; 7'h0E: vk = 8'h08; 7'h0F: vk = 8'h09;
			7'h10: vk = 8'h51; 7'h11: vk = 8'h57; 7'h12: vk = 8'h45; 7'h13: vk = 8'h52;
			7'h14: vk = 8'h54; 7'h15: vk = 8'h59; 7'h16: vk = 8'h55; 7'h17: vk = 8'h49;
			7'h18: vk = 8'h4F; 7'h19: vk = 8'h50; 7'h1A: vk = 8'hDB; 7'h1B: vk = 8'hDD;
			7'h1C: vk = 8'h0D; 7'h1D: vk = 8'h11; 7'h1E: vk = 8'h41; 7'h1F: vk = 8'h53;
			7'h20: vk = 8'h44; 7'h21: vk = 8'h46; 7'h22: vk = 8'h47; 7'h23: vk = 8'h48;
			7'h24: vk = 8'h4A; 7'h25: vk = 8'h4B; 7'h26: vk = 8'h4C; 7'h27: vk = 8'hBA;
			7'h28: vk = 8'hDE; 7'h29: vk = 8'hC0; 7'h2A: vk = 8'h10; 7'h2B: vk = 8'hDC;
			7'h2C: vk = 8'h5A; 7'h2D: vk = 8'h58; 7'h2E: vk = 8'h43; 7'h2F: vk = 8'h56;
			7'h30: vk = 8'h42; 7'h31: vk = 8'h4E; 7'h32: vk = 8'h4D; 7'h33: vk = 8'hBC;
			7'h34: vk = 8'hBE; 7'h35: vk = 8'hBF; 7'h36: vk = 8'h10; 7'h37: vk = 8'h6A;
			7'h38: vk = 8'h12; 7'h39: vk = 8'h20; 7'h3A: vk = 8'h14; 7'h3B: vk = 8'h70;
			7'h3C: vk = 8'h71; 7'h3D: vk = 8'h72; 7'h3E: vk = 8'h73; 7'h3F: vk = 8'h74;
			7'h40: vk = 8'h75; 7'h41: vk = 8'h76; 7'h42: vk = 8'h77; 7'h43: vk = 8'h78;
			7'h44: vk = 8'h79; 7'h45: vk = 8'h90; 7'h46: vk = 8'h91; 7'h47: vk = 8'h24;
			7'h48: vk = 8'h26; 7'h49: vk = 8'h21; 7'h4A: vk = 8'h6D; 7'h4B: vk = 8'h25;
			7'h4C: vk = 8'h0C; 7'h4D: vk = 8'h27; 7'h4E: vk = 8'h6B; 7'h4F: vk = 8'h23;
			7'h50: vk = 8'h28; 7'h51: vk = 8'h22; 7'h52: vk = 8'h2D; 7'h53: vk = 8'h2E;
			7'h54: vk = 8'h2B; 7'h57: vk = 8'h7A; 7'h58: vk = 8'h7B; 7'h5B: vk = 8'h5B;
			7'h5C: vk = 8'h5C; 7'h5D: vk = 8'h5D; 7'h7F: vk = 8'h13;
			default: vk = 8'h00;
		endcase
		return vk;
	endfunction

	// keypad keys with Num Lock on
	function automatic logic [7:0] pad_vk(input logic [6:0] code);
		logic [7:0] vk;
		unique case (code)
			7'h47: vk = 8'h67; 7'h48: vk = 8'h68; 7'h49: vk = 8'h69; 7'h4A: vk = 8'h6D;
			7'h4B: vk = 8'h64; 7'h4C: vk = 8'h65; 7'h4D: vk = 8'h66; 7'h4E: vk = 8'h6B;
			7'h4F: vk = 8'h61; 7'h50: vk = 8'h62; 7'h51: vk = 8'h63; 7'h52: vk = 8'h60;
			7'h53: vk = 8'h6E;
			default: vk = 8'h00;
		endcase
		return vk;
	endfunction

endpackage

@@ hdl/sc1kd_ascii.sv @@
module sc1kd_ascii (
	input  logic [7:0] vk,
	input  logic       down,
	input  logic [7:0] mods,
	output logic [6:0] ascii_char
);
	import sc1kd_pkg::*;

	logic shift;
	logic any_ctrl;
	logic any_alt;
	logic upper;

	always_comb begin
		shift    = mods[MOD_SHIFT];
		any_ctrl = mods[MOD_RCTRL] | mods[MOD_LCTRL];
		any_alt  = mods[MOD_RALT] | mods[MOD_LALT];
		upper    = mods[MOD_CAPS] ^ shift;
		ascii_char = 7'h00;
		if ((any_alt && any_ctrl) || (!down && any_alt)) begin
			ascii_char = 7'h00;
		end else if (any_ctrl) begin
			// control characters
			if (vk >= 8'h41 && vk <= 8'h5A) begin
				ascii_char = 7'(vk - 8'h40);
			end else begin
				unique case (vk)
					8'h20:   ascii_char = 7'h20;
					8'h08:   ascii_char = 7'h7F;
					8'h0D:   ascii_char = 7'h0D;
					8'hDB:   ascii_char = shift ? 7'h00 : 7'h1B;
					8'hDC:   ascii_char = shift ? 7'h00 : 7'h1C;
					8'hDD:   ascii_char = shift ? 7'h00 : 7'h1D;
					default: ascii_char = 7'h00;
				endcase
			end
		end else if (vk >= 8'h41 && vk <= 8'h5A) begin
			ascii_char = upper ? vk[6:0] : 7'(vk + 8'h20);
		end else if (vk >= 8'h30 && vk <= 8'h39) begin
			if (!shift) begin
				ascii_char = vk[6:0];
			end else begin
				unique case (vk[3:0])
					4'h0:    ascii_char = 7'h29;
					4'h1:    ascii_char = 7'h21;
					4'h2:    ascii_char = 7'h40;
					4'h3:    ascii_char = 7'h23;
					4'h4:    ascii_char = 7'h24;
					4'h5:    ascii_char = 7'h25;
					4'h6:    ascii_char = 7'h5E;
					4'h7:    ascii_char = 7'h26;
					4'h8:    ascii_char = 7'h2A;
					default: ascii_char = 7'h28;
				endcase
			end
		end else if (vk >= 8'h60 && vk <= 8'h6F) begin
			// numeric keypad
			unique case (vk[3:0])
				4'hA:    ascii_char = 7'h2A;
				4'hB:    ascii_char = 7'h2B;
				4'hC:    ascii_char = 7'h00;
				4'hD:    ascii_char = 7'h2D;
				4'hE:    ascii_char = 7'h2E;
				4'hF:    ascii_char = 7'h2F;
				default: ascii_char = {3'b011, vk[3:0]};
			endcase
		end else begin
			unique case (vk)
				8'hBA:   ascii_char = shift ? 7'h3A : 7'h3B;
				8'hBB:   ascii_char = shift ? 7'h2B : 7'h3D;
				8'hBC:   ascii_char = shift ? 7'h3C : 7'h2C;
				8'hBD:   ascii_char = shift ? 7'h5F : 7'h2D;
				8'hBE:   ascii_char = shift ? 7'h3E : 7'h2E;
				8'hBF:   ascii_char = shift ? 7'h3F : 7'h2F;
				8'hC0:   ascii_char = shift ? 7'h7E : 7'h60;
				8'hDB:   ascii_char = shift ? 7'h7B : 7'h5B;
				8'hDC:   ascii_char = shift ? 7'h7C : 7'h5C;
				8'hDD:   ascii_char = shift ? 7'h7D : 7'h5D;
				8'hDE:   ascii_char = shift ? 7'h22 : 7'h27;
				8'h20:   ascii_char = 7'h20;
				8'h0D:   ascii_char = 7'h0D;
				8'h08:   ascii_char = 7'h08;
				8'h09:   ascii_char = 7'h09;
				default: ascii_char = 7'h00;
			endcase
		end
	end

endmodule

@@ hdl/sc1kd_decode.sv @@
module sc1kd_decode (
	input  logic [7:0]              scan_byte,
	input  sc1kd_pkg::kbd_state_t   st,
	output sc1kd_pkg::kbd_state_t   nxt,
	output logic                    res_valid,
	output sc1kd_pkg::key_event_t   ev
);
	import sc1kd_pkg::*;

	logic       down;
	logic [6:0] code;
	logic [6:0] eff;
	logic       pause;
	logic [7:0] mods_t;
	logic [2:0] led_t;
	logic [2:0] held_t;
	logic       upd;
	logic [2:0] held_m;
	logic [7:0] mod_m;
	logic [2:0] led_m;
	logic [7:0] vk;
	logic [6:0] ch;

	sc1kd_ascii u_ascii (
		.vk        (vk),
		.down      (down),
		.mods      (mods_t),
		.ascii_char(ch)
	);

	// modifier and lock tracking, virtual key lookup
	always_comb begin
		down   = ~scan_byte[7];
		code   = scan_byte[6:0];
		pause  = st.ext && (st.pfx == PFX_E1_1D);
		eff    = pause ? CODE_PAUSE : code;
		mods_t = st.mods;
		led_t  = st.led;
		held_t = st.held;
		upd    = 1'b0;
		held_m = '0;
		mod_m  = '0;
		led_m  = '0;
		unique case (eff)
			CODE_CTRL: begin
				if (st.ext) mods_t[MOD_RCTRL] = down;
				else        mods_t[MOD_LCTRL] = down;
			end
			CODE_LSHIFT, CODE_RSHIFT: mods_t[MOD_SHIFT] = down;
			CODE_ALT: begin
				if (st.ext) mods_t[MOD_RALT] = down;
				else        mods_t[MOD_LALT] = down;
			end
			CODE_CAPS: begin
				held_m[HELD_CAPS] = 1'b1;
				mod_m[MOD_CAPS]   = 1'b1;
				led_m[LED_CAPS]   = 1'b1;
			end
			CODE_NUM: begin
				held_m[HELD_NUM] = 1'b1;
				mod_m[MOD_NUM]   = 1'b1;
				led_m[LED_NUM]   = 1'b1;
			end
			CODE_SCROLL: begin
				held_m[HELD_SCROLL] = 1'b1;
				mod_m[MOD_SCROLL]   = 1'b1;
				led_m[LED_SCROLL]   = 1'b1;
			end
			default: ;
		endcase
		// locks are frozen while either Ctrl is down
		if (held_m != 3'b000 && !(st.mods[MOD_RCTRL] || st.mods[MOD_LCTRL])) begin
			if (!down) begin
				held_t = held_t & ~held_m;
			end else if ((held_t & held_m) == 3'b000) begin
				held_t = held_t | held_m;
				upd    = 1'b1;
				if ((mods_t & mod_m) != 8'h00) begin
					mods_t = mods_t & ~mod_m;
					led_t  = led_t & ~led_m;
				end else begin
					mods_t = mods_t | mod_m;
					led_t  = led_t | led_m;
				end
			end
		end

		if (eff >= CODE_PAD_FIRST && eff <= CODE_PAD_LAST && mods_t[MOD_NUM] &&
		    !st.ext && !mods_t[MOD_SHIFT]) begin
			vk = pad_vk(eff);
		end else if (eff == CODE_SLASH && st.ext) begin
			vk = VK_NUM_SLASH;
		end else if (eff == CODE_STAR && st.ext) begin
			vk = VK_SNAPSHOT;
		end else begin
			vk = base_vk(eff);
		end
	end

	// prefix sequencing
	always_comb begin
		nxt       = st;
		nxt.ext   = 1'b0;
		nxt.pfx   = PFX_NONE;
		res_valid = 1'b0;
		if (scan_byte == SC_PFX_E0 || scan_byte == SC_PFX_E1) begin
			nxt.ext = 1'b1;
			nxt.pfx = (scan_byte == SC_PFX_E0) ? PFX_E0 : PFX_E1;
		end else if (st.ext && (code == CODE_LSHIFT || code == CODE_RSHIFT)) begin
			// fake shift, dropped
		end else if (st.ext && st.pfx == PFX_E1) begin
			if (code == CODE_CTRL) begin
				nxt.ext = 1'b1;
				nxt.pfx = PFX_E1_1D;
			end
		end else if (pause && code != CODE_NUM) begin
			// broken pause sequence, dropped
		end else begin
			nxt.mods  = mods_t;
			nxt.led   = led_t;
			nxt.held  = held_t;
			res_valid = 1'b1;
		end
	end

	always_comb begin
		ev.key_down      = down;
		ev.virtual_key   = vk;
		ev.key_scan      = eff;
		ev.ascii_char    = ch;
		ev.control_state = {st.ext, mods_t};
		ev.led_update    = upd;
		ev.led_bits      = led_t;
	end

endmodule

@@ hdl/scan_code_set1_key_decoder_unit.sv @@
// Scan code set 1 key decoder. Takes raw keyboard bytes (one per s_ transaction)
// and emits one key event per make or break code on the m_ side. Prefix bytes
// E0/E1, the fake shifts E0 2A / E0 36, and broken pause sequences produce no
// event; E1 1D 45 is reported as scan code 0x7F. The decoder tracks Ctrl, Alt,
// Shift and the three locks; Caps/Num/Scroll toggle on a fresh press unless a
// Ctrl key is down, and such an event carries led_update=1 with the new LED
// byte in led_bits (led_bits is valid on every event). Throughput is one byte
// per clock unless an event byte waits on m_tready: the input register feeds a
// single level of decode logic that updates the keyboard state and loads the
// event register in the same cycle. Bytes pass the input register, then the
// event register. The input side keeps taking bytes while an event waits for
// m_tready, as long as the waiting byte does not itself need the blocked event
// register. Reset clears all keyboard state (no prefix, no modifiers, LEDs off).
module scan_code_set1_key_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sc1kd_pkg::IN_W-1:0]   s_tdata,  // [7:0] scan_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] key_down, [8:1] virtual_key, [15:9] key_scan, [22:16] ascii_char,
	// [31:23] control_state, [32] led_update, [35:33] led_bits, [39:36] zero
	output logic [sc1kd_pkg::OUT_W-1:0]  m_tdata
);
	import sc1kd_pkg::*;

	localparam int EV_W = $bits(key_event_t);

	logic       valid_s1;
	logic [7:0] byte_s1;
	kbd_state_t state_q;
	kbd_state_t state_nxt;
	logic       res_valid;
	key_event_t ev;
	logic       out_valid_q;
	key_event_t out_ev_q;
	logic       out_free;
	logic       advance;

	sc1kd_decode u_decode (
		.scan_byte(byte_s1),
		.st       (state_q),
		.nxt      (state_nxt),
		.res_valid(res_valid),
		.ev       (ev)
	);

	// a byte that yields no event never waits on the output side
	assign out_free = ~out_valid_q | m_tready;
	assign advance  = valid_s1 & (~res_valid | out_free);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{ext: 1'b0, pfx: PFX_NONE, mods: '0, led: '0, held: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_ev_q <= ev;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_W - EV_W)'(0), out_ev_q};

endmodule

@@ hdl/sc1kd_checker.sv @@
module sc1kd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [sc1kd_pkg::IN_W-1:0]  s_tdata,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [sc1kd_pkg::OUT_W-1:0] m_tdata
);
	import sc1kd_pkg::*;

	key_event_t ev;

	assign ev = m_tdata[$bits(key_event_t)-1:0];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("event dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("event changed while stalled");

	// lock modifier bits and LED bits move together
	a_led_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ev.control_state[MOD_CAPS] == ev.led_bits[LED_CAPS]) &&
		             (ev.control_state[MOD_NUM] == ev.led_bits[LED_NUM]) &&
		             (ev.control_state[MOD_SCROLL] == ev.led_bits[LED_SCROLL]))
		else $error("lock state and LED bits disagree");

	// toggles only happen on presses
	a_led_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ev.led_update |-> ev.key_down)
		else $error("LED update on key release");

	a_pause_vk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ev.key_scan == CODE_PAUSE |-> ev.virtual_key == 8'h13)
		else $error("pause event with wrong virtual key");

endmodule

bind scan_code_set1_key_decoder_unit sc1kd_checker u_sc1kd_checker (.*);
